/* design/tpv_pkg.sv */
// ----------------------------------------------------------------------------
// tpv_pkg
// shared widths, latencies, codes and bundles of the trapezoidal path
// velocity pipeline
// ----------------------------------------------------------------------------
package tpv_pkg;

   localparam int MAX_AXES   = 6;
   localparam int AXIS_COUNT = 6;
   localparam int STEP_W     = 16;
   localparam int OFF_W      = 32;
   localparam int CFG_W      = 31;
   localparam int STATUS_W   = 3;
   localparam int CSR_AW     = 2;
   localparam int FRAC_W     = 16;

   localparam int REQ_W   = STEP_W + MAX_AXES * OFF_W;
   localparam int RSP_RAW = MAX_AXES * OFF_W + STATUS_W;
   localparam int RSP_W   = ((RSP_RAW + 7) / 8) * 8;

   // radix-2 divider, one quotient bit per stage
   localparam int DIV_QW  = 32;
   localparam int DIV_LAT = DIV_QW;

   localparam int PROF_LAT  = 2 * DIV_LAT + 5;
   localparam int AXIS_LAT  = 2 * DIV_LAT + 4;
   localparam int TOTAL_LAT = PROF_LAT + AXIS_LAT + 3;

   localparam logic [CFG_W-1:0]  PATH_LENGTH_RST = 31'd65536;
   localparam logic [CFG_W-1:0]  CRUISE_RST      = 31'd117965;
   localparam logic [STEP_W-1:0] STEP_COUNT_RST  = 16'd100;
   localparam logic [CFG_W-1:0]  TIME_STEP_RST   = 31'd6554;

   localparam logic [OFF_W-1:0] SAT_POS     = 32'h7fff_ffff;
   localparam logic [OFF_W-1:0] SAT_NEG_MAG = 32'h8000_0000;

   typedef enum logic [CSR_AW-1:0] {
      CSR_PATH_LENGTH     = 2'd0,
      CSR_CRUISE_VELOCITY = 2'd1,
      CSR_STEP_COUNT      = 2'd2,
      CSR_TIME_STEP       = 2'd3
   } csr_addr_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK          = 3'd0,
      ST_STEP_RANGE  = 3'd1,
      ST_CRUISE_LOW  = 3'd2,
      ST_CRUISE_HIGH = 3'd3,
      ST_TIME_RANGE  = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      SEG_ACCEL  = 2'd0,
      SEG_CRUISE = 2'd1,
      SEG_DECEL  = 2'd2
   } seg_type;

   typedef struct packed {
      logic [STEP_W-1:0] n;
      logic [CFG_W-1:0]  len;
      logic [CFG_W-1:0]  vc;
      logic [CFG_W-1:0]  dif;
      logic [CFG_W-1:0]  dif_half;
      logic [DIV_QW-1:0] dif2;
   } prof_cfg_type;

   typedef struct packed {
      logic [CFG_W-1:0] len;
      logic [CFG_W-1:0] dt;
   } axis_cfg_type;

endpackage

/* design/tpv_div.sv */
// ----------------------------------------------------------------------------
// tpv_div
// pipelined restoring divider, one quotient bit per stage; the upper half
// of the dividend must be below the divisor
// ----------------------------------------------------------------------------
module tpv_div (
   input  logic                             clock,
   input  logic                             adv,
   input  logic [2*tpv_pkg::DIV_QW-1:0]     dividend,
   input  logic [tpv_pkg::DIV_QW-1:0]       divisor,
   output logic [tpv_pkg::DIV_QW-1:0]       quotient
);
   import tpv_pkg::*;

   logic [DIV_QW-1:0] rem_ff [DIV_LAT];
   logic [DIV_QW-1:0] lo_ff  [DIV_LAT];
   logic [DIV_QW-1:0] quo_ff [DIV_LAT];
   logic [DIV_QW-1:0] dsr_ff [DIV_LAT];
   logic [DIV_QW-1:0] rem_in [DIV_LAT];
   logic [DIV_QW-1:0] lo_in  [DIV_LAT];
   logic [DIV_QW-1:0] quo_in [DIV_LAT];
   logic [DIV_QW-1:0] dsr_in [DIV_LAT];

   for (genvar j = 0; j < DIV_LAT; j++) begin : g_stage
      logic [DIV_QW-1:0] src_rem, src_lo, src_quo, src_dsr;
      logic [DIV_QW:0]   trial;
      logic              take;

      if (j == 0) begin : g_first
         assign src_rem = dividend[2*DIV_QW-1:DIV_QW];
         assign src_lo  = dividend[DIV_QW-1:0];
         assign src_quo = '0;
         assign src_dsr = divisor;
      end else begin : g_next
         assign src_rem = rem_ff[j-1];
         assign src_lo  = lo_ff[j-1];
         assign src_quo = quo_ff[j-1];
         assign src_dsr = dsr_ff[j-1];
      end

      assign trial     = {src_rem, src_lo[DIV_QW-1]};
      assign take      = trial >= {1'b0, src_dsr};
      assign rem_in[j] = take ? DIV_QW'(trial - {1'b0, src_dsr}) : trial[DIV_QW-1:0];
      assign lo_in[j]  = {src_lo[DIV_QW-2:0], 1'b0};
      assign quo_in[j] = {src_quo[DIV_QW-2:0], take};
      assign dsr_in[j] = src_dsr;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int j = 0; j < DIV_LAT; j++) begin
            rem_ff[j] <= rem_in[j];
            lo_ff[j]  <= lo_in[j];
            quo_ff[j] <= quo_in[j];
            dsr_ff[j] <= dsr_in[j];
         end
      end
   end

   assign quotient = quo_ff[DIV_LAT-1];

endmodule

/* design/tpv_profile.sv */
// ----------------------------------------------------------------------------
// tpv_profile
// trapezoidal position at step k: segment pick, speed by step count,
// square over twice the ramp span
// ----------------------------------------------------------------------------
module tpv_profile (
   input  logic                        clock,
   input  logic                        adv,
   input  logic [tpv_pkg::STEP_W-1:0]  k,
   input  tpv_pkg::prof_cfg_type       cfg,
   output logic [tpv_pkg::CFG_W-1:0]   s
);
   import tpv_pkg::*;

   localparam int PROD_W = CFG_W + STEP_W;
   localparam int WW_W   = 2 * CFG_W;

   logic [PROD_W-1:0] kv_ff, dn_ff, ln_ff, vm_ff;
   logic [STEP_W-1:0] k1_ff, m_ff, m_in;
   seg_type           seg_in, seg2_ff, seg3_ff, seg36_ff;
   seg_type           seg_dly_ff  [DIV_LAT];
   seg_type           seg_dly2_ff [DIV_LAT];
   logic [DIV_QW-1:0] w_q, q2;
   logic [WW_W-1:0]   ww_ff;
   logic [CFG_W-1:0]  cru_ff;
   logic [CFG_W-1:0]  cru_dly_ff [DIV_LAT];
   logic [CFG_W-1:0]  s_ff, s_in;

   // exact segment choice on the cross products
   always_comb begin
      if (kv_ff <= dn_ff) begin
         seg_in = SEG_ACCEL;
      end else if (kv_ff <= ln_ff) begin
         seg_in = SEG_CRUISE;
      end else begin
         seg_in = SEG_DECEL;
      end
      m_in = (seg_in == SEG_DECEL) ? STEP_W'(cfg.n - k1_ff) : k1_ff;
   end

   always_comb begin
      case (seg_dly2_ff[DIV_LAT-1])
         SEG_ACCEL:  s_in = q2[CFG_W-1:0];
         SEG_CRUISE: s_in = cru_dly_ff[DIV_LAT-1];
         SEG_DECEL:  s_in = CFG_W'(cfg.len - q2[CFG_W-1:0]);
         default:    s_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         kv_ff   <= PROD_W'(cfg.vc) * PROD_W'(k);
         dn_ff   <= PROD_W'(cfg.dif) * PROD_W'(cfg.n);
         ln_ff   <= PROD_W'(cfg.len) * PROD_W'(cfg.n);
         k1_ff   <= k;
         seg2_ff <= seg_in;
         m_ff    <= m_in;
         vm_ff   <= PROD_W'(cfg.vc) * PROD_W'(m_ff);
         seg3_ff <= seg2_ff;
         seg_dly_ff[0] <= seg3_ff;
         for (int j = 1; j < DIV_LAT; j++) begin
            seg_dly_ff[j] <= seg_dly_ff[j-1];
         end
         ww_ff    <= WW_W'(w_q[CFG_W-1:0]) * WW_W'(w_q[CFG_W-1:0]);
         cru_ff   <= CFG_W'(w_q[CFG_W-1:0] - cfg.dif_half);
         seg36_ff <= seg_dly_ff[DIV_LAT-1];
         seg_dly2_ff[0] <= seg36_ff;
         cru_dly_ff[0]  <= cru_ff;
         for (int j = 1; j < DIV_LAT; j++) begin
            seg_dly2_ff[j] <= seg_dly2_ff[j-1];
            cru_dly_ff[j]  <= cru_dly_ff[j-1];
         end
         s_ff <= s_in;
      end
   end

   tpv_div u_div_speed (
      .clock    (clock),
      .adv      (adv),
      .dividend ((2*DIV_QW)'(vm_ff)),
      .divisor  (DIV_QW'(cfg.n)),
      .quotient (w_q)
   );

   tpv_div u_div_square (
      .clock    (clock),
      .adv      (adv),
      .dividend ((2*DIV_QW)'(ww_ff)),
      .divisor  (cfg.dif2),
      .quotient (q2)
   );

   assign s = s_ff;

endmodule

/* design/tpv_axis.sv */
// ----------------------------------------------------------------------------
// tpv_axis
// one axis lane: offset times profile step over path length, over time
// step, signed and saturated
// ----------------------------------------------------------------------------
module tpv_axis (
   input  logic                              clock,
   input  logic                              adv,
   input  logic signed [tpv_pkg::OFF_W-1:0]  off,
   input  logic [tpv_pkg::CFG_W-1:0]         mag_ds,
   input  logic                              ds_neg,
   input  tpv_pkg::axis_cfg_type             cfg,
   output logic signed [tpv_pkg::OFF_W-1:0]  vel
);
   import tpv_pkg::*;

   localparam int PROD_W = OFF_W + CFG_W;
   localparam int NUM_W  = DIV_QW + FRAC_W;

   logic [OFF_W-1:0]  mag_off_ff, mag_off_in;
   logic [CFG_W-1:0]  mds_ff;
   logic              neg1_ff, neg2_ff, neg35_ff;
   logic [PROD_W-1:0] prod_ff;
   logic              neg_dly_ff  [DIV_LAT];
   logic              neg_dly2_ff [DIV_LAT];
   logic              ovf_dly_ff  [DIV_LAT];
   logic [DIV_QW-1:0] r_q, v_q;
   logic              ovf_ff;
   logic [NUM_W-1:0]  num_ff;
   logic [OFF_W-1:0]  vel_ff, vel_in;

   assign mag_off_in = off[OFF_W-1] ? OFF_W'(~off + 1'b1) : off;

   always_comb begin
      if (neg_dly2_ff[DIV_LAT-1]) begin
         if (ovf_dly_ff[DIV_LAT-1] || v_q > SAT_NEG_MAG) begin
            vel_in = OFF_W'(~SAT_NEG_MAG + 1'b1);
         end else begin
            vel_in = OFF_W'(~v_q + 1'b1);
         end
      end else if (ovf_dly_ff[DIV_LAT-1] || v_q > SAT_POS) begin
         vel_in = SAT_POS;
      end else begin
         vel_in = v_q;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         mag_off_ff <= mag_off_in;
         neg1_ff    <= off[OFF_W-1] ^ ds_neg;
         mds_ff     <= mag_ds;
         prod_ff    <= PROD_W'(mag_off_ff) * PROD_W'(mds_ff);
         neg2_ff    <= neg1_ff;
         neg_dly_ff[0] <= neg2_ff;
         for (int j = 1; j < DIV_LAT; j++) begin
            neg_dly_ff[j] <= neg_dly_ff[j-1];
         end
         // a quotient of 2^32 or more saturates in any case
         ovf_ff   <= CFG_W'(r_q[DIV_QW-1:FRAC_W]) >= cfg.dt;
         num_ff   <= {r_q, {FRAC_W{1'b0}}};
         neg35_ff <= neg_dly_ff[DIV_LAT-1];
         neg_dly2_ff[0] <= neg35_ff;
         ovf_dly_ff[0]  <= ovf_ff;
         for (int j = 1; j < DIV_LAT; j++) begin
            neg_dly2_ff[j] <= neg_dly2_ff[j-1];
            ovf_dly_ff[j]  <= ovf_dly_ff[j-1];
         end
         vel_ff <= vel_in;
      end
   end

   tpv_div u_div_len (
      .clock    (clock),
      .adv      (adv),
      .dividend ((2*DIV_QW)'(prod_ff)),
      .divisor  (DIV_QW'(cfg.len)),
      .quotient (r_q)
   );

   tpv_div u_div_dt (
      .clock    (clock),
      .adv      (adv),
      .dividend ((2*DIV_QW)'(num_ff)),
      .divisor  (DIV_QW'(cfg.dt)),
      .quotient (v_q)
   );

   assign vel = vel_ff;

endmodule

/* design/trapezoidal_path_velocity.sv */
// ----------------------------------------------------------------------------
// trapezoidal_path_velocity
// step command in, six saturated Q16.16 velocities and a status code out
// throughput: one word per cycle while rsp is not stalled, set by the fully
//   pipelined datapath of two 32-stage radix-2 dividers in each profile lane
//   and in each axis lane
// a stall on rsp freezes every stage at once; nothing is dropped or repeated
// reset (synchronous) clears the valid bits and loads the register defaults
// ----------------------------------------------------------------------------
module trapezoidal_path_velocity (
   input  logic                          clock,
   input  logic                          reset,
   // req word
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // step [15:0], offset_x, offset_y, offset_z, offset_roll, offset_pitch,
   // offset_yaw (32 bits each, upward from bit 16)
   input  logic [tpv_pkg::REQ_W-1:0]     req_tdata,
   // rsp word
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // vel_x, vel_y, vel_z, rate_roll, rate_pitch, rate_yaw (32 bits each
   // from bit 0), status [194:192], zero fill
   output logic [tpv_pkg::RSP_W-1:0]     rsp_tdata,
   // register writes
   input  logic                          csr_we,
   input  tpv_pkg::csr_addr_type         csr_addr,
   input  logic [tpv_pkg::CFG_W-1:0]     csr_wdata
);
   import tpv_pkg::*;

   localparam int OFF_DLY = PROF_LAT + 1;
   localparam int ST_DLY  = PROF_LAT + AXIS_LAT + 1;

   // configuration registers
   logic [CFG_W-1:0]  path_ff, cruise_ff, tstep_ff;
   logic [STEP_W-1:0] count_ff;
   // derived values, refreshed every cycle
   prof_cfg_type      pcfg_ff, pcfg_in;
   axis_cfg_type      acfg_ff, acfg_in;

   // pipeline control
   logic                  adv;
   logic [TOTAL_LAT-1:0]  vld_ff;

   // entry stage
   logic [STEP_W-1:0]        step_in, k_ff;
   logic signed [OFF_W-1:0]  off_in [MAX_AXES];
   logic signed [OFF_W-1:0]  off_ff [MAX_AXES];
   status_type               status_in, status_ff;
   logic                     compute_in, compute_ff;

   // side delay lines
   logic [PROF_LAT-1:0]      kz_dly_ff;
   logic signed [OFF_W-1:0]  off_dly_ff [OFF_DLY][MAX_AXES];
   status_type               st_dly_ff [ST_DLY];
   logic [ST_DLY-1:0]        cmp_dly_ff;

   // profile step
   logic [CFG_W-1:0]  s_cur, s_prev, s_prev_eff;
   logic [CFG_W-1:0]  mds_ff, mds_in;
   logic              dneg_ff, dneg_in;

   // result stage
   logic signed [OFF_W-1:0]  axis_vel [MAX_AXES];
   logic signed [OFF_W-1:0]  vel_ff [MAX_AXES];
   status_type               stat_ff;

   // whole pipeline moves when the output slot is free or being taken
   assign adv        = !vld_ff[TOTAL_LAT-1] || rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = vld_ff[TOTAL_LAT-1];

   // register file, masked to each register's width
   always_ff @(posedge clock) begin
      if (reset) begin
         path_ff   <= PATH_LENGTH_RST;
         cruise_ff <= CRUISE_RST;
         count_ff  <= STEP_COUNT_RST;
         tstep_ff  <= TIME_STEP_RST;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_PATH_LENGTH:     path_ff   <= csr_wdata;
            CSR_CRUISE_VELOCITY: cruise_ff <= csr_wdata;
            CSR_STEP_COUNT:      count_ff  <= csr_wdata[STEP_W-1:0];
            CSR_TIME_STEP:       tstep_ff  <= csr_wdata;
         endcase
      end
   end

   // ramp span, twice it and half of it rounded up; zero time step reads as one
   always_comb begin
      pcfg_in.n        = count_ff;
      pcfg_in.len      = path_ff;
      pcfg_in.vc       = cruise_ff;
      pcfg_in.dif      = CFG_W'(cruise_ff - path_ff);
      pcfg_in.dif2     = {pcfg_in.dif, 1'b0};
      pcfg_in.dif_half = CFG_W'(({1'b0, pcfg_in.dif} + 1'b1) >> 1);
      acfg_in.len      = path_ff;
      acfg_in.dt       = (tstep_ff == '0) ? CFG_W'(1) : tstep_ff;
   end

   always_ff @(posedge clock) begin
      pcfg_ff <= pcfg_in;
      acfg_ff <= acfg_in;
   end

   // unpack the req word
   assign step_in = req_tdata[STEP_W-1:0];
   for (genvar i = 0; i < MAX_AXES; i++) begin : g_unpack
      assign off_in[i] = req_tdata[STEP_W + i*OFF_W +: OFF_W];
   end

   // first error wins; step zero still runs, its earlier position being zero
   always_comb begin
      compute_in = 1'b0;
      if (step_in >= count_ff) begin
         status_in = ST_STEP_RANGE;
      end else if (path_ff >= cruise_ff) begin
         status_in = ST_CRUISE_LOW;
      end else if ({path_ff, 1'b0} < {1'b0, cruise_ff}) begin
         status_in = ST_CRUISE_HIGH;
      end else begin
         compute_in = 1'b1;
         status_in  = (step_in == '0) ? ST_TIME_RANGE : ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[TOTAL_LAT-2:0], req_tvalid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         k_ff       <= step_in;
         status_ff  <= status_in;
         compute_ff <= compute_in;
         for (int i = 0; i < MAX_AXES; i++) begin
            off_ff[i]        <= off_in[i];
            off_dly_ff[0][i] <= off_ff[i];
         end
         for (int j = 1; j < OFF_DLY; j++) begin
            for (int i = 0; i < MAX_AXES; i++) begin
               off_dly_ff[j][i] <= off_dly_ff[j-1][i];
            end
         end
         kz_dly_ff    <= {kz_dly_ff[PROF_LAT-2:0], k_ff == '0};
         cmp_dly_ff   <= {cmp_dly_ff[ST_DLY-2:0], compute_ff};
         st_dly_ff[0] <= status_ff;
         for (int j = 1; j < ST_DLY; j++) begin
            st_dly_ff[j] <= st_dly_ff[j-1];
         end
      end
   end

   // positions at this step and at the one before
   tpv_profile u_prof_cur (
      .clock (clock),
      .adv   (adv),
      .k     (k_ff),
      .cfg   (pcfg_ff),
      .s     (s_cur)
   );

   tpv_profile u_prof_prev (
      .clock (clock),
      .adv   (adv),
      .k     (STEP_W'(k_ff - 1'b1)),
      .cfg   (pcfg_ff),
      .s     (s_prev)
   );

   // position step as magnitude and sign
   always_comb begin
      s_prev_eff = kz_dly_ff[PROF_LAT-1] ? '0 : s_prev;
      if (s_cur >= s_prev_eff) begin
         mds_in  = CFG_W'(s_cur - s_prev_eff);
         dneg_in = 1'b0;
      end else begin
         mds_in  = CFG_W'(s_prev_eff - s_cur);
         dneg_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         mds_ff  <= mds_in;
         dneg_ff <= dneg_in;
      end
   end

   // one lane per axis in use, the rest read zero
   for (genvar i = 0; i < MAX_AXES; i++) begin : g_axis
      if (i < AXIS_COUNT) begin : g_used
         tpv_axis u_axis (
            .clock  (clock),
            .adv    (adv),
            .off    (off_dly_ff[OFF_DLY-1][i]),
            .mag_ds (mds_ff),
            .ds_neg (dneg_ff),
            .cfg    (acfg_ff),
            .vel    (axis_vel[i])
         );
      end else begin : g_unused
         assign axis_vel[i] = '0;
      end
   end

   // output register, velocities cleared on a rejected step
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < MAX_AXES; i++) begin
            vel_ff[i] <= cmp_dly_ff[ST_DLY-1] ? axis_vel[i] : '0;
         end
         stat_ff <= st_dly_ff[ST_DLY-1];
      end
   end

   always_comb begin
      rsp_tdata = '0;
      for (int i = 0; i < MAX_AXES; i++) begin
         rsp_tdata[i*OFF_W +: OFF_W] = vel_ff[i];
      end
      rsp_tdata[MAX_AXES*OFF_W +: STATUS_W] = stat_ff;
   end

   // checks that any status but ok leaves every velocity at zero; step zero runs with a non-ok status
   a_error_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && stat_ff != ST_OK) |-> (rsp_tdata[MAX_AXES*OFF_W-1:0] == '0))
      else $error("velocity not zero with error status");

   // a held output freezes the valid chain
   a_stall_hold : assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(vld_ff))
      else $error("pipeline moved during stall");

   // nothing comes out straight after reset
   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid after reset");

endmodule
